// ===== src/elevator_collective_controller_core_assert.svh =====
`ifndef ELEVATOR_COLLECTIVE_CONTROLLER_CORE_ASSERT_SVH
`define ELEVATOR_COLLECTIVE_CONTROLLER_CORE_ASSERT_SVH

// Assertion helpers; the using module supplies clk and rst_n.

// Consequent holds in the same cycle as the antecedent.
`define ECC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ecc_pkg.sv =====
package ecc_pkg;

    // Request codes
    localparam logic [2:0] REQ_HALL_UP   = 3'd0;
    localparam logic [2:0] REQ_HALL_DOWN = 3'd1;
    localparam logic [2:0] REQ_CAR_DEST  = 3'd2;
    localparam logic [2:0] REQ_PULSE     = 3'd3;
    localparam logic [2:0] REQ_TICK      = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_UP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_DOWN_WIDTH = 2'd1;
    localparam logic [1:0] CFG_DELAY      = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [11:0] UP_WIDTH_RST   = 12'd2000;
    localparam logic [11:0] DOWN_WIDTH_RST = 12'd1000;
    localparam logic [15:0] DELAY_RST      = 16'd5000;
    localparam logic [15:0] DELAY_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] target_floor;
    } req_t;

    typedef struct packed {
        logic [11:0] motor_width;
        logic        car_moving;
        logic [3:0]  car_floor;
        logic        heading_down;
        logic        stopped_here;
    } res_t;

    typedef struct packed {
        logic [11:0] up_width;
        logic [11:0] down_width;
        logic [15:0] restart_delay;
    } cfg_t;

endpackage

// ===== src/ecc_req_if.sv =====
interface ecc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [3:0] target_floor;

    modport source (output valid, output req_type, output target_floor, input ready);
    modport sink   (input valid, input req_type, input target_floor, output ready);
endinterface

// ===== src/ecc_res_if.sv =====
interface ecc_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] motor_width;
    logic        car_moving;
    logic [3:0]  car_floor;
    logic        heading_down;
    logic        stopped_here;

    modport source (output valid, output motor_width, output car_moving, output car_floor,
                    output heading_down, output stopped_here, input ready);
    modport sink   (input valid, input motor_width, input car_moving, input car_floor,
                    input heading_down, input stopped_here, output ready);
endinterface

// ===== src/ecc_ctrl.sv =====
`include "elevator_collective_controller_core_assert.svh"

module ecc_ctrl
    import ecc_pkg::*;
#(
    parameter int FLOORS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t item,
    input  cfg_t cfg,
    output res_t result
);

    localparam int FW = $clog2(FLOORS);
    localparam logic [FW-1:0] TOP = FW'(FLOORS - 1);
    localparam logic [FLOORS-1:0] ONE = {{(FLOORS-1){1'b0}}, 1'b1};

    logic [FW-1:0]     floor_reg, floor_next;
    logic              dir_reg, dir_next;
    logic              moving_reg, moving_next;
    logic [FLOORS-1:0] up_reg, up_next;
    logic [FLOORS-1:0] down_reg, down_next;
    logic [FLOORS-1:0] car_reg, car_next;
    logic              skip_reg, skip_next;
    logic              pend_reg, pend_next;
    logic [15:0]       delay_reg, delay_next;
    logic [11:0]       drive_reg, drive_next;
    logic              stopped;

    logic [5:0]        lvl_ext;
    logic [FW-1:0]     idx;
    logic [FLOORS-1:0] req_bit;
    logic [FLOORS-1:0] here_bit;
    logic [15:0]       delay_inc;
    logic [5:0]        floor_p1;

    function automatic logic work_ahead(input logic [FLOORS-1:0] any,
                                        input logic [FW-1:0] fl,
                                        input logic dn);
        logic [FLOORS-1:0] side;
        for (int i = 0; i < FLOORS; i++) begin
            side[i] = dn ? (FW'(i) < fl) : (FW'(i) > fl);
        end
        return |(any & side);
    endfunction

    assign lvl_ext = 6'(item.target_floor);
    assign idx     = FW'(lvl_ext - 6'd1);
    assign req_bit = ONE << idx;

    always_comb
    begin
        floor_next  = floor_reg;
        dir_next    = dir_reg;
        moving_next = moving_reg;
        up_next     = up_reg;
        down_next   = down_reg;
        car_next    = car_reg;
        skip_next   = skip_reg;
        pend_next   = pend_reg;
        delay_next  = delay_reg;
        drive_next  = drive_reg;
        stopped     = 1'b0;
        here_bit    = '0;
        delay_inc   = delay_reg;

        if (step)
        begin
            unique case (item.req_type)
                REQ_HALL_UP, REQ_HALL_DOWN, REQ_CAR_DEST:
                begin
                    if (lvl_ext >= 6'd1 && lvl_ext <= 6'(FLOORS))
                    begin
                        // idle car sets off toward the new call
                        if (!moving_reg && idx != floor_reg)
                        begin
                            dir_next    = (idx < floor_reg);
                            pend_next   = 1'b0;
                            moving_next = 1'b1;
                            drive_next  = dir_next ? cfg.down_width : cfg.up_width;
                        end
                        if (item.req_type == REQ_HALL_UP)
                        begin
                            if (idx != floor_reg)
                                up_next = up_reg | req_bit;
                        end
                        else if (item.req_type == REQ_HALL_DOWN)
                        begin
                            if (idx != floor_reg)
                                down_next = down_reg | req_bit;
                        end
                        else if (dir_next ? (idx < floor_reg) : (idx > floor_reg))
                        begin
                            car_next = car_reg | req_bit;
                        end
                    end
                end
                REQ_PULSE:
                begin
                    if (moving_reg)
                    begin
                        if (skip_reg)
                        begin
                            skip_next = 1'b0;
                        end
                        else
                        begin
                            if (dir_reg)
                            begin
                                if (floor_reg != '0)
                                    floor_next = floor_reg - FW'(1);
                            end
                            else if (floor_reg != TOP)
                            begin
                                floor_next = floor_reg + FW'(1);
                            end
                            if (floor_next == TOP)
                                dir_next = 1'b1;
                            else if (floor_next == '0)
                                dir_next = 1'b0;
                            here_bit = ONE << floor_next;

                            if ((car_reg & here_bit) != '0 ||
                                ((dir_next ? down_reg : up_reg) & here_bit) != '0)
                            begin
                                // stop for a destination or a call our way
                                if (dir_next)
                                    down_next = down_reg & ~here_bit;
                                else
                                    up_next = up_reg & ~here_bit;
                                car_next    = car_reg & ~here_bit;
                                moving_next = 1'b0;
                                drive_next  = '0;
                                skip_next   = 1'b1;
                                delay_next  = '0;
                                pend_next   = work_ahead(up_next | down_next | car_next,
                                                         floor_next, dir_next);
                                stopped     = 1'b1;
                            end
                            else if (((dir_next ? up_reg : down_reg) & here_bit) != '0 &&
                                     !work_ahead(up_reg | down_reg | car_reg,
                                                 floor_next, dir_next))
                            begin
                                // nothing ahead: take the opposite call and turn round
                                if (dir_next)
                                    up_next = up_reg & ~here_bit;
                                else
                                    down_next = down_reg & ~here_bit;
                                car_next    = car_reg & ~here_bit;
                                moving_next = 1'b0;
                                drive_next  = '0;
                                skip_next   = 1'b1;
                                dir_next    = ~dir_next;
                                pend_next   = 1'b0;
                                delay_next  = '0;
                                stopped     = 1'b1;
                            end
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (!moving_reg && pend_reg)
                    begin
                        if (delay_reg != DELAY_MAX)
                            delay_inc = delay_reg + 16'd1;
                        delay_next = delay_inc;
                        if (delay_inc >= cfg.restart_delay)
                        begin
                            pend_next   = 1'b0;
                            delay_next  = '0;
                            moving_next = 1'b1;
                            drive_next  = dir_reg ? cfg.down_width : cfg.up_width;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg  <= '0;
            dir_reg    <= 1'b0;
            moving_reg <= 1'b0;
            up_reg     <= '0;
            down_reg   <= '0;
            car_reg    <= '0;
            skip_reg   <= 1'b1;
            pend_reg   <= 1'b0;
            delay_reg  <= '0;
            drive_reg  <= '0;
        end
        else
        begin
            floor_reg  <= floor_next;
            dir_reg    <= dir_next;
            moving_reg <= moving_next;
            up_reg     <= up_next;
            down_reg   <= down_next;
            car_reg    <= car_next;
            skip_reg   <= skip_next;
            pend_reg   <= pend_next;
            delay_reg  <= delay_next;
            drive_reg  <= drive_next;
        end
    end

    assign floor_p1 = 6'(floor_next) + 6'd1;

    always_comb
    begin
        result.motor_width  = drive_next;
        result.car_moving   = moving_next;
        result.car_floor    = floor_p1[3:0];
        result.heading_down = dir_next;
        result.stopped_here = stopped;
    end

    `ECC_ASSERT_SAME(a_idle_no_drive, !moving_reg, drive_reg == '0,
                     "drive width non-zero while the car is stopped")
    `ECC_ASSERT_NEXT(a_stop_halts, stopped, !moving_reg && skip_reg,
                     "stop did not halt the car")
    `ECC_ASSERT_NEXT(a_idle_floor_holds, !moving_reg, $stable(floor_reg),
                     "floor changed while stopped")
    `ECC_ASSERT_SAME(a_floor_range, 1'b1, floor_reg <= TOP,
                     "floor index beyond top floor")

endmodule

// ===== src/elevator_collective_controller_core.sv =====
// Directional collective elevator controller. Each request transaction is one event
// (hall up call, hall down call, car destination, floor-sensor pulse or 1 ms tick)
// and produces exactly one result transaction showing the car state after it:
// motor pulse width, moving flag, floor (1-based), heading and whether this event
// stopped the car. One transaction is taken every clock cycle unless an untaken result
// stalls the pipe; each passes through the request register, a single pass of the step
// logic and the result register. The result register lets a new request enter while an
// untaken result waits. Configuration (drive widths, restart delay) is written
// through cfg_we/cfg_index/cfg_wdata and must only change while no transaction is
// in flight. No clearing pass after reset: the block is ready at once.
module elevator_collective_controller_core
    import ecc_pkg::*;
#(
    parameter int FLOORS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ecc_req_if.sink               req,
    ecc_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_width      <= UP_WIDTH_RST;
            cfg_reg.down_width    <= DOWN_WIDTH_RST;
            cfg_reg.restart_delay <= DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UP_WIDTH:   cfg_reg.up_width      <= cfg_wdata[11:0];
                CFG_DOWN_WIDTH: cfg_reg.down_width    <= cfg_wdata[11:0];
                CFG_DELAY:      cfg_reg.restart_delay <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Request register: holds one transaction ahead of the step logic
    logic s1_vld_reg;
    req_t s1_item_reg;
    logic out_vld_reg;
    res_t out_reg;
    res_t step_res;
    logic advance;

    // The step fires when a request is held and the result slot is free or draining
    assign advance   = s1_vld_reg && (!out_vld_reg || res.ready);
    assign req.ready = !s1_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg.req_type     <= req.req_type;
            s1_item_reg.target_floor <= req.target_floor;
        end
    end

    ecc_ctrl #(
        .FLOORS (FLOORS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (step_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.motor_width  = out_reg.motor_width;
    assign res.car_moving   = out_reg.car_moving;
    assign res.car_floor    = out_reg.car_floor;
    assign res.heading_down = out_reg.heading_down;
    assign res.stopped_here = out_reg.stopped_here;

endmodule
